>>> sv/interval_priority_task_scheduler_assert.svh
// Assertion macros shared by the scheduler RTL.
`ifndef INTERVAL_PRIORITY_TASK_SCHEDULER_ASSERT_SVH
`define INTERVAL_PRIORITY_TASK_SCHEDULER_ASSERT_SVH

// Checked at every rising edge while reset is released.
`define IPTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define IPTS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> sv/ipts_pkg.sv
// Types, constants and codes of the interval priority task scheduler.
`timescale 1ns / 1ps
`default_nettype none

package ipts_pkg;

  localparam int SLOTS     = 16;
  localparam int TIME_BITS = 32;
  localparam int IDX_W     = $clog2(SLOTS);
  localparam int CNT_W     = $clog2(SLOTS + 1);

  localparam logic [7:0] FLAG_NIBBLE  = 8'hf0;
  localparam logic [7:0] PRIO_NIBBLE  = 8'h0f;
  localparam logic [7:0] FLAG_STOPPED = 8'h80;
  localparam logic [7:0] FLAG_WAITING = 8'h40;
  localparam logic [7:0] FLAG_RUNNING = 8'h20;
  localparam logic [TIME_BITS-1:0] INTERVAL_TRIM = TIME_BITS'(4);

  typedef enum logic [2:0] {
    ACT_ADD       = 3'd0,
    ACT_SCHEDULE  = 3'd1,
    ACT_FINISHED  = 3'd2,
    ACT_SET_WAIT  = 3'd3,
    ACT_CLR_WAIT  = 3'd4
  } ipts_action_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2
  } ipts_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LOOKUP,
    S_MODIFY,
    S_WRITE,
    S_DONE
  } ipts_state_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] now;
    logic [31:0] interval;
    logic [7:0]  status_byte;
    logic [3:0]  max_priority;
    logic [3:0]  task_index;
  } ipts_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] slot;
  } ipts_out_t;

  typedef struct packed {
    logic [7:0]           status;
    logic [TIME_BITS-1:0] interval;
    logic [TIME_BITS-1:0] last_start;
  } ipts_entry_t;

  typedef struct packed {
    logic [IDX_W-1:0]     addr;
    logic                 status_en;
    logic                 interval_en;
    logic                 start_en;
    logic [7:0]           status;
    logic [TIME_BITS-1:0] interval;
    logic [TIME_BITS-1:0] last_start;
  } ipts_wr_t;

endpackage

`default_nettype wire

>>> sv/interval_priority_task_scheduler.sv
// Top level of the interval priority task scheduler with its sequencer.
`timescale 1ns / 1ps
`default_nettype none

// The block keeps a table of task slots and serves one request transaction
// at a time on the input channel (in_valid_i / in_ready_o / in_data_i).
// Every request yields exactly one result transaction on the output channel
// (out_valid_o / out_ready_i / out_data_o): a status code and a slot number.
//
// Add and schedule walk the slots in use through the single read port of
// the table, one slot per cycle, with one shared subtract-and-compare unit
// judging whether a slot's interval has elapsed. An add that meets a stopped
// slot or a schedule that meets a priority 0 candidate stops the walk early.
// Finished, set waiting and clear waiting on a slot in use do one
// read-modify-write (lookup, modify, done); with an index past the table,
// and for other codes, the sequencer goes straight to its done state.
//
// in_ready_o is high only while the sequencer is idle. A result sits in an
// output register; if the receiver stalls, the sequencer waits with the next
// result until the register is free, and the held result never changes.
// Reset empties the table (task count zero) and drops any pending result;
// slot contents are not cleared since only slots in use are ever read.
module interval_priority_task_scheduler (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire ipts_pkg::ipts_in_t    in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output ipts_pkg::ipts_out_t        out_data_o
);

`include "interval_priority_task_scheduler_assert.svh"

  ipts_pkg::ipts_state_e state_q, state_d;

  logic [ipts_pkg::CNT_W-1:0] task_count_q, task_count_d;
  logic [ipts_pkg::CNT_W-1:0] rd_ptr_q, rd_ptr_d;
  logic                       pend_q, pend_d;
  logic                       out_valid_q, out_valid_d;

  ipts_pkg::ipts_in_t         req_q, req_d;
  logic [ipts_pkg::IDX_W-1:0] eval_ptr_q, eval_ptr_d;
  logic                       found_q, found_d;
  logic [ipts_pkg::IDX_W-1:0] pick_q, pick_d;
  logic [7:0]                 best_q, best_d;
  ipts_pkg::ipts_out_t        res_q, res_d;
  ipts_pkg::ipts_out_t        out_q, out_d;

  logic                       rd_en;
  logic [ipts_pkg::IDX_W-1:0] rd_addr;
  ipts_pkg::ipts_entry_t      rd_data;
  ipts_pkg::ipts_wr_t         wr;

  logic                           in_fire;
  logic                           is_add;
  logic                           out_free;
  logic [ipts_pkg::TIME_BITS-1:0] now_t;
  logic [ipts_pkg::TIME_BITS-1:0] elapsed;
  logic                           due;
  logic                           hit_add;
  logic                           cand;
  logic                           better;
  logic                           stop;
  logic                           scan_done;

  ipts_table u_table (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_i      (wr)
  );

  assign in_ready_o  = (state_q == ipts_pkg::S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // Slot checks of the request being served; the slot read last cycle is judged now.
  always_comb begin
    is_add    = (req_q.action == ipts_pkg::ACT_ADD);
    now_t     = ipts_pkg::TIME_BITS'(req_q.now);
    elapsed   = now_t - rd_data.last_start;
    due       = (elapsed >= rd_data.interval);
    hit_add   = pend_q && ((rd_data.status & ipts_pkg::FLAG_STOPPED) != 8'h00);
    cand      = pend_q && ((rd_data.status & ipts_pkg::FLAG_NIBBLE) == 8'h00) &&
                (rd_data.status[3:0] <= req_q.max_priority) && due;
    better    = cand && (rd_data.status < best_q);
    stop      = is_add ? hit_add : (better && (rd_data.status == 8'h00));
    scan_done = stop || (rd_ptr_q >= task_count_q);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ipts_pkg::S_IDLE: begin
        if (in_valid_i) begin
          case (in_data_i.action)
            ipts_pkg::ACT_ADD,
            ipts_pkg::ACT_SCHEDULE: state_d = ipts_pkg::S_SCAN;
            ipts_pkg::ACT_FINISHED,
            ipts_pkg::ACT_SET_WAIT,
            ipts_pkg::ACT_CLR_WAIT: begin
              if (32'(in_data_i.task_index) < 32'(task_count_q)) begin
                state_d = ipts_pkg::S_LOOKUP;
              end else begin
                state_d = ipts_pkg::S_DONE;
              end
            end
            default: state_d = ipts_pkg::S_DONE;
          endcase
        end
      end
      ipts_pkg::S_SCAN: begin
        if (scan_done) begin
          state_d = ipts_pkg::S_WRITE;
        end
      end
      ipts_pkg::S_LOOKUP: state_d = ipts_pkg::S_MODIFY;
      ipts_pkg::S_MODIFY: state_d = ipts_pkg::S_DONE;
      ipts_pkg::S_WRITE:  state_d = ipts_pkg::S_DONE;
      ipts_pkg::S_DONE: begin
        if (out_free) begin
          state_d = ipts_pkg::S_IDLE;
        end
      end
      default: state_d = ipts_pkg::S_IDLE;
    endcase
  end

  // Datapath control and table access.
  always_comb begin
    task_count_d = task_count_q;
    rd_ptr_d     = rd_ptr_q;
    pend_d       = 1'b0;
    out_valid_d  = out_valid_q && !out_ready_i;
    req_d        = req_q;
    eval_ptr_d   = eval_ptr_q;
    found_d      = found_q;
    pick_d       = pick_q;
    best_d       = best_q;
    res_d        = res_q;
    out_d        = out_q;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr           = '0;

    case (state_q)
      ipts_pkg::S_IDLE: begin
        if (in_fire) begin
          req_d    = in_data_i;
          rd_ptr_d = '0;
          found_d  = 1'b0;
          best_d   = ipts_pkg::PRIO_NIBBLE;
          res_d    = '{status: ipts_pkg::ST_OK, slot: 4'd0};
        end
      end
      ipts_pkg::S_SCAN: begin
        if (is_add ? hit_add : better) begin
          found_d = 1'b1;
          pick_d  = eval_ptr_q;
          best_d  = rd_data.status;
        end
        if (!scan_done) begin
          rd_en      = 1'b1;
          rd_addr    = rd_ptr_q[ipts_pkg::IDX_W-1:0];
          eval_ptr_d = rd_ptr_q[ipts_pkg::IDX_W-1:0];
          rd_ptr_d   = rd_ptr_q + 1'b1;
          pend_d     = 1'b1;
        end
      end
      ipts_pkg::S_LOOKUP: begin
        rd_en   = 1'b1;
        rd_addr = ipts_pkg::IDX_W'(req_q.task_index);
      end
      ipts_pkg::S_MODIFY: begin
        wr.addr      = ipts_pkg::IDX_W'(req_q.task_index);
        wr.status_en = 1'b1;
        case (req_q.action)
          ipts_pkg::ACT_FINISHED: wr.status = rd_data.status & ~ipts_pkg::FLAG_RUNNING;
          ipts_pkg::ACT_SET_WAIT: wr.status = rd_data.status | ipts_pkg::FLAG_WAITING;
          default:                wr.status = rd_data.status & ~ipts_pkg::FLAG_WAITING;
        endcase
      end
      ipts_pkg::S_WRITE: begin
        wr.interval   = ipts_pkg::TIME_BITS'(req_q.interval) - ipts_pkg::INTERVAL_TRIM;
        wr.last_start = now_t;
        if (is_add) begin
          wr.status = req_q.status_byte;
          if (found_q) begin
            wr.addr        = pick_q;
            wr.status_en   = 1'b1;
            wr.interval_en = 1'b1;
            wr.start_en    = 1'b1;
            res_d          = '{status: ipts_pkg::ST_OK, slot: 4'(pick_q)};
          end else if (task_count_q == ipts_pkg::CNT_W'(ipts_pkg::SLOTS)) begin
            res_d = '{status: ipts_pkg::ST_FULL, slot: 4'd0};
          end else begin
            wr.addr        = task_count_q[ipts_pkg::IDX_W-1:0];
            wr.status_en   = 1'b1;
            wr.interval_en = 1'b1;
            wr.start_en    = 1'b1;
            task_count_d   = task_count_q + 1'b1;
            res_d          = '{status: ipts_pkg::ST_OK, slot: 4'(task_count_q)};
          end
        end else begin
          // The chosen slot had a clear flag nibble, so its new status is the
          // priority with only the running flag set.
          wr.status = best_q | ipts_pkg::FLAG_RUNNING;
          if (found_q) begin
            wr.addr      = pick_q;
            wr.status_en = 1'b1;
            wr.start_en  = 1'b1;
            res_d        = '{status: ipts_pkg::ST_OK, slot: 4'(pick_q)};
          end else begin
            res_d = '{status: ipts_pkg::ST_NONE, slot: 4'd0};
          end
        end
      end
      ipts_pkg::S_DONE: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ipts_pkg::S_IDLE;
      task_count_q <= '0;
      rd_ptr_q     <= '0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      task_count_q <= task_count_d;
      rd_ptr_q     <= rd_ptr_d;
      pend_q       <= pend_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    eval_ptr_q <= eval_ptr_d;
    found_q    <= found_d;
    pick_q     <= pick_d;
    best_q     <= best_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  // The table never holds more tasks than it has slots.
  `IPTS_ASSERT_ALWAYS(a_count_bound, task_count_q <= ipts_pkg::CNT_W'(ipts_pkg::SLOTS), "task count beyond slot count")

  // The task count only ever grows by one at a time.
  `IPTS_ASSERT(a_count_step, (task_count_q != $past(task_count_q)) |-> (task_count_q == $past(task_count_q) + 1'b1), "task count jumped")

  // A request in service keeps the next one out in the cycle after its acceptance.
  `IPTS_ASSERT(a_busy_after_accept, in_fire |=> !in_ready_o, "accepted a request while busy")

  // A full report only comes from a table with every slot in use.
  `IPTS_ASSERT(a_full_report, (state_q == ipts_pkg::S_DONE && res_q.status == ipts_pkg::ST_FULL) |-> (task_count_q == ipts_pkg::CNT_W'(ipts_pkg::SLOTS)), "table full reported early")

  // The table is written only while a request is in service.
  `IPTS_ASSERT(a_write_busy, (wr.status_en || wr.start_en) |-> (state_q != ipts_pkg::S_IDLE), "table written while idle")

endmodule

`default_nettype wire

>>> sv/ipts_table.sv
// Task slot table: status, interval and last start memories with one read port.
`timescale 1ns / 1ps
`default_nettype none

module ipts_table (
  input  wire logic                      clk_i,
  input  wire logic                      rd_en_i,
  input  wire logic [ipts_pkg::IDX_W-1:0] rd_addr_i,
  output ipts_pkg::ipts_entry_t          rd_data_o,
  input  wire ipts_pkg::ipts_wr_t        wr_i
);

  logic [7:0]                     status_mem [ipts_pkg::SLOTS];
  logic [ipts_pkg::TIME_BITS-1:0] interval_mem [ipts_pkg::SLOTS];
  logic [ipts_pkg::TIME_BITS-1:0] start_mem [ipts_pkg::SLOTS];

  ipts_pkg::ipts_entry_t rd_q;

  // Each field has its own write enable so a schedule can leave the interval alone.
  always_ff @(posedge clk_i) begin
    if (wr_i.status_en) begin
      status_mem[wr_i.addr] <= wr_i.status;
    end
    if (wr_i.interval_en) begin
      interval_mem[wr_i.addr] <= wr_i.interval;
    end
    if (wr_i.start_en) begin
      start_mem[wr_i.addr] <= wr_i.last_start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q.status     <= status_mem[rd_addr_i];
      rd_q.interval   <= interval_mem[rd_addr_i];
      rd_q.last_start <= start_mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for the interval priority task scheduler.
`timescale 1ns / 1ps

module testbench;
  import ipts_pkg::*;

  // Action codes 5 to 7 have no meaning; the block must answer them with a
  // plain done result and leave the table alone.
  localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

  // Longest request is a full scan plus setup and writeback.
  localparam int DRAIN_CYCLES = SLOTS + 8;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  ipts_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  ipts_out_t out_data_o;

  interval_priority_task_scheduler dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // The 4 ns clock runs for the whole simulation.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Shadow copy of the task table. Only slots below task_count are ever
  // read, matching the block, so stale entries never matter.
  int                   task_count;
  logic [7:0]           slot_status [SLOTS];
  logic [TIME_BITS-1:0] slot_interval [SLOTS];
  logic [TIME_BITS-1:0] slot_start [SLOTS];

  // Results predicted at request acceptance, oldest first.
  ipts_out_t expected_results [$];

  // Percent chance per cycle that the sender or the receiver holds off.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  // Current time presented with each request; it wraps freely.
  logic [TIME_BITS-1:0] clock_us;

  int fail_count;
  int requests_sent;
  int results_checked;
  int tasks_dispatched;
  int dispatch_misses;
  int stopped_reuses;
  int full_rejects;

  ipts_out_t got_result;
  ipts_out_t want_result;

  // Index of the first stopped slot in use, or -1 when there is none.
  function automatic int first_stopped_slot();
    int c;
    int hit;
    hit = -1;
    for (c = 0; c < task_count; c++) begin
      if (hit < 0 && (slot_status[c] & FLAG_STOPPED) != 8'h00) begin
        hit = c;
      end
    end
    return hit;
  endfunction

  // Applies one request to the shadow table and returns the result the
  // block must give for it.
  function automatic ipts_out_t apply_request(ipts_in_t req);
    ipts_out_t            res;
    int                   pick;
    int                   c;
    logic [7:0]           best;
    logic [7:0]           st;
    logic [TIME_BITS-1:0] elapsed;
    int                   chosen;
    res.status = ST_OK;
    res.slot   = '0;
    case (req.action)
      ACT_ADD: begin
        pick = first_stopped_slot();
        if (pick < 0 && task_count >= SLOTS) begin
          res.status = ST_FULL;
          full_rejects++;
        end else begin
          if (pick < 0) begin
            pick       = task_count;
            task_count = task_count + 1;
          end else begin
            stopped_reuses++;
          end
          slot_interval[pick] = req.interval - INTERVAL_TRIM;
          slot_start[pick]    = req.now;
          slot_status[pick]   = req.status_byte;
          res.slot            = 4'(pick);
        end
      end
      ACT_SCHEDULE: begin
        // Strict less-than keeps the first index on a tie and never lets a
        // priority 15 task win.
        best   = PRIO_NIBBLE;
        chosen = -1;
        for (c = 0; c < task_count; c++) begin
          st      = slot_status[c];
          elapsed = req.now - slot_start[c];
          if ((st & FLAG_NIBBLE) == 8'h00 && st <= {4'h0, req.max_priority} &&
              elapsed >= slot_interval[c] && st < best) begin
            best   = st;
            chosen = c;
          end
        end
        if (chosen < 0) begin
          res.status = ST_NONE;
          dispatch_misses++;
        end else begin
          slot_start[chosen]  = req.now;
          slot_status[chosen] = slot_status[chosen] | FLAG_RUNNING;
          res.slot            = 4'(chosen);
          tasks_dispatched++;
        end
      end
      ACT_FINISHED: begin
        if (req.task_index < task_count) begin
          slot_status[req.task_index] = slot_status[req.task_index] & ~FLAG_RUNNING;
        end
      end
      ACT_SET_WAIT: begin
        if (req.task_index < task_count) begin
          slot_status[req.task_index] = slot_status[req.task_index] | FLAG_WAITING;
        end
      end
      ACT_CLR_WAIT: begin
        if (req.task_index < task_count) begin
          slot_status[req.task_index] = slot_status[req.task_index] & ~FLAG_WAITING;
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Offers one request transaction and predicts its result once accepted.
  // Valid is left high after acceptance so that a back-to-back request is
  // a single assignment; an idle gap or the drain lowers it.
  task automatic send_request(ipts_in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    expected_results.push_back(apply_request(req));
    requests_sent++;
  endtask

  // Builds a request with every field filled in; the caller overrides what
  // a directed check needs.
  function automatic ipts_in_t base_request(ipts_action_e act);
    ipts_in_t req;
    req.action       = act;
    req.now          = clock_us;
    req.interval     = $urandom_range(150, 4);
    req.status_byte  = {4'h0, 4'($urandom_range(15))};
    req.max_priority = 4'hf;
    req.task_index   = 4'($urandom_range(15));
    return req;
  endfunction

  task automatic send_action(ipts_action_e act, logic [TIME_BITS-1:0] at,
                             logic [7:0] sbyte, logic [31:0] ivl,
                             logic [3:0] maxp, logic [3:0] idx);
    ipts_in_t req;
    req              = base_request(act);
    req.now          = at;
    req.status_byte  = sbyte;
    req.interval     = ivl;
    req.max_priority = maxp;
    req.task_index   = idx;
    send_request(req);
  endtask

  // Receiver: stalls at random and checks each result transaction against
  // the oldest prediction. Signals are read right after the edge, so they
  // still hold the values that decided the handshake.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_result = out_data_o;
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected: status %0d slot %0d",
                 $time, got_result.status, got_result.slot);
        fail_count++;
      end else begin
        want_result = expected_results.pop_front();
        results_checked++;
        if (got_result.status !== want_result.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want_result.status, got_result.status);
          fail_count++;
        end
        if (got_result.slot !== want_result.slot) begin
          $display("%0t: slot mismatch: expected %0d, actual %0d",
                   $time, want_result.slot, got_result.slot);
          fail_count++;
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // An empty table: schedule finds nothing and index actions hit no slot.
  task automatic test_empty_table();
    send_action(ACT_SCHEDULE, 32'h0000_0000, 8'h00, 32'd4, 4'hf, 4'h0);
    send_action(ACT_FINISHED, 32'h0000_0000, 8'h00, 32'd4, 4'hf, 4'h0);
    send_action(ACT_SET_WAIT, 32'hffff_ffff, 8'hff, 32'hffff_ffff, 4'h0, 4'hf);
  endtask

  // Appending slots, then reusing a stopped one. The first two are added
  // just before the time wraps, the smallest and largest intervals among
  // them.
  task automatic test_add_and_reuse();
    send_action(ACT_ADD, 32'hffff_fff0, 8'h05, 32'd4, 4'hf, 4'h0);
    send_action(ACT_ADD, 32'hffff_fff8, 8'h00, 32'hffff_ffff, 4'hf, 4'h0);
    send_action(ACT_ADD, 32'hffff_fffa, 8'h8f, 32'h8000_0000, 4'hf, 4'h0);
    send_action(ACT_ADD, 32'hffff_fffc, 8'h03, 32'd20, 4'hf, 4'h0);
  endtask

  // Eligibility: the priority limit, elapsed time across the wrap, tasks
  // already running, priority 15 never chosen, and an interval met exactly.
  task automatic test_schedule_rules();
    send_action(ACT_SCHEDULE, 32'h0000_0010, 8'h00, 32'd4, 4'h4, 4'h0);
    send_action(ACT_SCHEDULE, 32'h0000_0010, 8'h00, 32'd4, 4'hf, 4'h0);
    send_action(ACT_SCHEDULE, 32'h0000_0010, 8'h00, 32'd4, 4'hf, 4'h0);
    send_action(ACT_ADD, 32'h0000_0010, 8'h0f, 32'd4, 4'hf, 4'h0);
    send_action(ACT_SCHEDULE, 32'h0000_0014, 8'h00, 32'd4, 4'hf, 4'h0);
    send_action(ACT_SCHEDULE, 32'hffff_fff3, 8'h00, 32'd4, 4'h0, 4'h0);
  endtask

  // Running and waiting flags, an index past the table, and the spare
  // action codes.
  task automatic test_flag_actions();
    ipts_in_t req;
    int       code;
    send_action(ACT_FINISHED, 32'h0000_0100, 8'h00, 32'd4, 4'hf, 4'h0);
    send_action(ACT_SET_WAIT, 32'h0000_0100, 8'h00, 32'd4, 4'hf, 4'h0);
    send_action(ACT_SCHEDULE, 32'h0000_0200, 8'h00, 32'd4, 4'hf, 4'h0);
    send_action(ACT_CLR_WAIT, 32'h0000_0200, 8'h00, 32'd4, 4'hf, 4'h0);
    send_action(ACT_FINISHED, 32'h0000_0200, 8'h00, 32'd4, 4'hf, 4'h2);
    send_action(ACT_SCHEDULE, 32'h0000_0300, 8'h00, 32'd4, 4'hf, 4'h0);
    send_action(ACT_FINISHED, 32'h0000_0300, 8'h00, 32'd4, 4'hf, 4'he);
    for (code = int'(ACT_SPARE_FIRST); code <= int'(ACT_SPARE_LAST); code++) begin
      req        = base_request(ACT_ADD);
      req.action = 3'(code);
      req.now    = $urandom();
      send_request(req);
    end
    clock_us = 32'h0000_0400;
  endtask

  // Fills every slot with live tasks, then adds are turned away.
  task automatic test_table_full();
    while (task_count < SLOTS || first_stopped_slot() >= 0) begin
      clock_us = clock_us + 32'($urandom_range(20));
      send_action(ACT_ADD, clock_us, {4'h0, 4'($urandom_range(15))},
                  $urandom_range(100, 4), 4'hf, 4'h0);
    end
    send_action(ACT_ADD, clock_us, 8'h01, 32'd50, 4'hf, 4'h0);
    send_action(ACT_ADD, clock_us, 8'h80, 32'hffff_ffff, 4'hf, 4'hf);
  endtask

  // One random request, weighted toward the dispatch cycle of add,
  // schedule and finish with moving time.
  function automatic ipts_in_t random_request();
    ipts_in_t    req;
    int unsigned pick;
    pick = $urandom_range(99);
    if ($urandom_range(99) < 3) begin
      clock_us = $urandom();
    end else begin
      clock_us = clock_us + 32'($urandom_range(60));
    end
    req = base_request(ACT_ADD);
    if (pick < 22) begin
      req.action = ACT_ADD;
    end else if (pick < 57) begin
      req.action = ACT_SCHEDULE;
    end else if (pick < 80) begin
      req.action = ACT_FINISHED;
    end else if (pick < 88) begin
      req.action = ACT_SET_WAIT;
    end else if (pick < 95) begin
      req.action = ACT_CLR_WAIT;
    end else begin
      req.action = 3'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST));
    end
    pick = $urandom_range(99);
    if (pick < 10) begin
      req.interval = $urandom_range(8, 4);
    end else if (pick < 20) begin
      req.interval = $urandom();
      if (req.interval < 4) req.interval = 4;
    end
    pick = $urandom_range(99);
    if (pick < 20) begin
      req.status_byte = FLAG_STOPPED | {4'h0, 4'($urandom_range(15))};
    end else if (pick < 40) begin
      req.status_byte = 8'($urandom_range(255));
    end
    if ($urandom_range(99) < 30) req.max_priority = 4'($urandom_range(15));
    if (task_count > 0 && $urandom_range(99) < 85) begin
      req.task_index = 4'($urandom_range(task_count - 1));
    end
    return req;
  endfunction

  task automatic test_random_traffic(int count);
    int n;
    for (n = 0; n < count; n++) begin
      send_request(random_request());
    end
  endtask

  // Lower valid, let every result come back, then watch a few more cycles
  // for stray results before reporting.
  task automatic finish_run();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_results.size());
      fail_count++;
    end
    $display("Sent %0d requests and checked %0d results, %0d errors.",
             requests_sent, results_checked, fail_count);
    $display("Schedules: %0d dispatched, %0d idle; adds: %0d reused, %0d rejected full.",
             tasks_dispatched, dispatch_misses, stopped_reuses, full_rejects);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  endtask

  initial begin
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    out_ready_i <= 1'b0;
    rst_ni      <= 1'b0;
    task_count       = 0;
    clock_us         = '0;
    fail_count       = 0;
    requests_sent    = 0;
    results_checked  = 0;
    tasks_dispatched = 0;
    dispatch_misses  = 0;
    stopped_reuses   = 0;
    full_rejects     = 0;
    send_idle_pct    = 28;
    recv_idle_pct    = 46;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_add_and_reuse();
    test_schedule_rules();
    test_flag_actions();
    test_random_traffic(150);
    test_table_full();

    send_idle_pct = 46;
    recv_idle_pct = 28;
    test_random_traffic(140);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(140);

    finish_run();
  end

  // Far beyond the slowest legal run of about 500 requests.
  initial begin
    #2000000;
    $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
